@@ rtl/core/tbli_pkg.sv @@
// Package for the table linear interpolator core.
// Holds sizes, function and status codes, and the table point type.
// No dependencies; every other file in rtl/core imports it.
package tbli_pkg;

  localparam int unsigned POINTS    = 12;
  localparam int unsigned CNT_W     = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned MAG_W     = 2 * DATA_W;
  localparam int unsigned SUM_W     = MAG_W + 2;
  localparam int unsigned DIV_CNT_W = $clog2(MAG_W);

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_EXACT  = 2'd0,
    ST_INTERP = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BADSEG = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } point_t;

endpackage

@@ rtl/core/table_linear_interpolator_core.sv @@
// Table linear interpolator: a write transaction stores one point and gives no result.
// A query scans the rotation chain and returns its result for exact, out-of-range and
// zero-width cases; when it interpolates, it also runs the bit-serial divider.
// One query is in flight at a time and busy stays high until its result strobe.
// Reset (rst_ni low, async) clears control state only; table contents stay undefined.
module table_linear_interpolator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [tbli_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [tbli_pkg::DATA_W-1:0]  point_x_i,
  input  logic signed [tbli_pkg::DATA_W-1:0]  point_y_i,
  input  logic signed [tbli_pkg::DATA_W-1:0]  query_x_i,
  output logic                                done_o,
  output logic signed [tbli_pkg::DATA_W-1:0]  result_y_o,
  output logic [1:0]                          status_o
);
  import tbli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_MUL,
    S_DIV
  } state_e;

  state_e      state_q;
  logic [CNT_W-1:0] cnt_q;
  logic        hit_q;
  logic        exact_q;
  logic        done_q;
  logic signed [DATA_W-1:0] res_q;
  status_e     stat_q;

  // Datapath registers, no reset needed.
  logic signed [DATA_W-1:0] q_q;
  logic signed [DATA_W-1:0] x0_q;
  logic signed [DATA_W-1:0] y0_q;
  logic signed [DATA_W-1:0] x1_q;
  logic signed [DATA_W-1:0] y1_q;
  logic signed [PROD_W-1:0] prod_q;

  logic        acc;
  logic        wr_acc;
  logic        scan_shift;
  logic [POINTS-1:0] cell_ld;
  point_t      wr_pt;
  point_t      cell_pt [POINTS];

  logic        exact_now;
  logic        seg_now;
  logic        take;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dqx;
  logic signed [PROD_W-1:0] prod_d;

  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [MAG_W-1:0]  div_quot;
  logic [MAG_W-1:0]  prod_mag;
  logic [DATA_W-1:0] dx_mag;
  logic        quot_neg;
  logic signed [SUM_W-1:0] quot_s;
  logic signed [SUM_W-1:0] sum;
  logic signed [DATA_W-1:0] sat;

  // Handshake: a transaction is taken whenever start is high and the core is idle.
  assign busy   = (state_q != S_IDLE);
  assign acc    = start && !busy;
  assign wr_acc = acc && (func_i == FUNC_WRITE);

  assign wr_pt.x = point_x_i;
  assign wr_pt.y = point_y_i;

  // Rotate the whole table one slot per scan cycle. Cell 0 always shows point i
  // and cell 1 point i+1; after POINTS shifts every point is back in its own slot.
  assign scan_shift = (state_q == S_SCAN);

  for (genvar k = 0; k < POINTS; k++) begin : g_cell
    // Writes to a slot past the table match no cell and drop silently.
    assign cell_ld[k] = wr_acc && (int'(point_index_i) == k);

    tbli_cell u_cell (
      .clk_i     (clk_i),
      .ld_i      (cell_ld[k]),
      .shift_i   (scan_shift),
      .ld_pt_i   (wr_pt),
      .prev_pt_i (cell_pt[(k + 1) % POINTS]),
      .pt_o      (cell_pt[k])
    );
  end

  // Scan test at the head of the chain: exact match wins, then the first segment
  // whose upper x lies above the query. The last point has no segment above it.
  assign exact_now = (cell_pt[0].x == q_q);
  assign seg_now   = !exact_now && (cnt_q != CNT_W'(POINTS - 1)) && (cell_pt[1].x > q_q);
  assign take      = scan_shift && !hit_q && (exact_now || seg_now);

  // Segment arithmetic on the latched points.
  assign dx     = DIFF_W'(x1_q) - DIFF_W'(x0_q);
  assign dy     = DIFF_W'(y1_q) - DIFF_W'(y0_q);
  assign dqx    = DIFF_W'(q_q)  - DIFF_W'(x0_q);
  assign prod_d = dy * dqx;

  // Divide magnitudes, restore the sign after: this truncates toward zero.
  assign prod_mag = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : prod_q[MAG_W-1:0];
  assign dx_mag   = dx[DIFF_W-1] ? DATA_W'(-dx) : dx[DATA_W-1:0];
  assign quot_neg = prod_q[PROD_W-1] ^ dx[DIFF_W-1];
  assign div_start = (state_q == S_MUL);

  tbli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag),
    .divisor_i  (dx_mag),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign quot_s = quot_neg ? -SUM_W'(div_quot) : SUM_W'(div_quot);
  assign sum    = SUM_W'(y0_q) + quot_s;

  // Saturate the interpolated value to the signed 16-bit range.
  always_comb begin
    if (sum > SUM_W'(signed'(32'sd32767))) begin
      sat = DATA_W'(16'h7FFF);
    end else if (sum < SUM_W'(-32'sd32768)) begin
      sat = DATA_W'(16'h8000);
    end else begin
      sat = sum[DATA_W-1:0];
    end
  end

  // Control state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
      exact_q <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
      stat_q  <= ST_EXACT;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc && (func_i == FUNC_QUERY)) begin
            state_q <= S_SCAN;
            cnt_q   <= '0;
            hit_q   <= 1'b0;
            exact_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (take) begin
            hit_q   <= 1'b1;
            exact_q <= exact_now;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(POINTS - 1)) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (!hit_q) begin
            res_q   <= '0;
            stat_q  <= ST_RANGE;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (exact_q) begin
            res_q   <= y0_q;
            stat_q  <= ST_EXACT;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (dx == '0) begin
            res_q   <= '0;
            stat_q  <= ST_BADSEG;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= sat;
            stat_q  <= ST_INTERP;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: capture the query, the chosen points and the product.
  always_ff @(posedge clk_i) begin
    if (acc && (func_i == FUNC_QUERY)) begin
      q_q <= query_x_i;
    end
    if (take) begin
      x0_q <= cell_pt[0].x;
      y0_q <= cell_pt[0].y;
      x1_q <= cell_pt[1].x;
      y1_q <= cell_pt[1].y;
    end
    if (state_q == S_EVAL) begin
      prod_q <= prod_d;
    end
  end

  assign done_o     = done_q;
  assign result_y_o = res_q;
  assign status_o   = stat_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a query is still in flight");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while still iterating");

  a_exact_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exact_q |-> hit_q)
    else $error("exact match flagged without a scan hit");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV))
    else $error("divider iterating outside the divide state");
`endif

endmodule

@@ rtl/core/tbli_cell.sv @@
// One storage cell of the table rotation chain: holds a single point.
// Depends on tbli_pkg for the point type.
module tbli_cell (
  input  logic            clk_i,
  input  logic            ld_i,
  input  logic            shift_i,
  input  tbli_pkg::point_t ld_pt_i,
  input  tbli_pkg::point_t prev_pt_i,
  output tbli_pkg::point_t pt_o
);
  import tbli_pkg::*;

  point_t pt_q;

  // Load from the write port, or take the neighbor's point during a scan.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      pt_q <= ld_pt_i;
    end else if (shift_i) begin
      pt_q <= prev_pt_i;
    end
  end

  assign pt_o = pt_q;

endmodule

@@ rtl/core/tbli_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tbli_pkg for operand widths.
module tbli_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tbli_pkg::MAG_W-1:0]  dividend_i,
  input  logic [tbli_pkg::DATA_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [tbli_pkg::MAG_W-1:0]  quot_o
);
  import tbli_pkg::*;

  logic                 active_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W:0]      rem_q;
  logic [MAG_W-1:0]     quot_q;
  logic [DATA_W-1:0]    dvs_q;

  logic [DATA_W:0]      rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q[DATA_W-1:0], quot_q[MAG_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Shift in one dividend bit, subtract when the partial remainder allows.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (active_q) begin
      quot_q <= {quot_q[MAG_W-2:0], ge};
      rem_q  <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    end
  end

  assign busy_o = active_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ bench/tb_table_linear_interpolator_core.sv @@
// Self-checking bench for table_linear_interpolator_core: directed then random transactions.
// Depends on tbli_pkg and the core RTL; expected lookups come from a shadow copy of the table or inline rows.
module tb_table_linear_interpolator_core;
  import tbli_pkg::*;

  localparam int ITEM_TARGET  = 1650;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 64;
  localparam int DIRECTED_N   = 26;

  localparam logic signed [DATA_W-1:0] V_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] V_MAX = 16'sh7FFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    status_e                  st;
  } lookup_t;

  typedef struct packed {
    func_e                    func;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] qx;
    logic                     typed;
    lookup_t                  want;
  } stim_row_t;

  localparam lookup_t UNTYPED = '{16'sd0, ST_EXACT};

  // Table for the directed part. The first twelve rows fill every slot so
  // that no later lookup touches an unwritten entry. Rows with typed = 1
  // carry their lookup inline; all others go through the shadow predictor.
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{FUNC_WRITE, 4'd0,  V_MIN,      V_MIN,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd1,  -16'sd256,  16'sd4096,  16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd2,  16'sd0,     16'sd0,     16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd3,  16'sd256,   V_MAX,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd4,  16'sd256,   16'sd100,   16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd5,  16'sd512,   V_MIN,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd6,  16'sd768,   V_MAX,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd7,  16'sd1024,  16'sd1234,  16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd8,  16'sd1280,  -16'sd4321, 16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd9,  16'sd1536,  16'sd0,     16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd10, 16'sd1792,  16'sd16384, 16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd11, 16'sd2048,  -16'sd1,    16'sd0,     1'b0, UNTYPED},
    // slot past the table: must be dropped
    '{FUNC_WRITE, 4'd12, V_MAX,      V_MAX,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_WRITE, 4'd15, -16'sd1,    -16'sd1,    V_MAX,      1'b0, UNTYPED},
    // exact hits at the lowest slot and at slot 2, then above the table
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     V_MIN,      1'b1, '{V_MIN, ST_EXACT}},
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     16'sd0,     1'b1, '{16'sd0, ST_EXACT}},
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     V_MAX,      1'b1, '{16'sd0, ST_RANGE}},
    // plain interpolation on two falling segments
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     -16'sd128,  1'b0, UNTYPED},
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     16'sd300,   1'b0, UNTYPED},
    // zero-width first segment with the query below it
    '{FUNC_WRITE, 4'd0,  -16'sd256,  16'sd5,     16'sd0,     1'b0, UNTYPED},
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     -16'sd1000, 1'b1, '{16'sd0, ST_BADSEG}},
    // unsorted first segment (negative width): saturates high
    '{FUNC_WRITE, 4'd0,  -16'sd255,  V_MIN,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     V_MIN,      1'b0, UNTYPED},
    // steep extrapolation below the table: saturates low
    '{FUNC_WRITE, 4'd0,  -16'sd512,  V_MIN,      16'sd0,     1'b0, UNTYPED},
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     V_MIN,      1'b0, UNTYPED},
    // quotient truncates toward zero
    '{FUNC_QUERY, 4'd0,  16'sd0,     16'sd0,     16'sd1,     1'b0, UNTYPED}
  };

  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic                     start         = 1'b0;
  logic                     busy;
  logic                     func_i        = 1'b0;
  logic [IDX_W-1:0]         point_index_i = '0;
  logic signed [DATA_W-1:0] point_x_i     = '0;
  logic signed [DATA_W-1:0] point_y_i     = '0;
  logic signed [DATA_W-1:0] query_x_i     = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] result_y_o;
  logic [1:0]               status_o;

  // Shadow of the point table and the lookups still owed by the core.
  logic signed [DATA_W-1:0] shadow_x [POINTS];
  logic signed [DATA_W-1:0] shadow_y [POINTS];
  lookup_t                  pending_lookups [$];

  int error_count   = 0;
  int write_count   = 0;
  int ignored_count = 0;
  int query_count   = 0;
  int burst_left    = 0;
  int status_count [4] = '{0, 0, 0, 0};

  table_linear_interpolator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .query_x_i     (query_x_i),
    .done_o        (done_o),
    .result_y_o    (result_y_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb_table_linear_interpolator_core: FAIL");
    $finish;
  end

  // Scan the shadow table the way the core does: first exact match wins,
  // else the first segment whose upper x lies above the query.
  function automatic lookup_t interpolate_at(logic signed [DATA_W-1:0] q);
    lookup_t r;
    longint  x0, x1, y0, y1, dx, sum;
    r.y  = '0;
    r.st = ST_RANGE;
    for (int i = 0; i < POINTS; i++) begin
      x0 = shadow_x[i];
      if (x0 == q) begin
        r.y  = shadow_y[i];
        r.st = ST_EXACT;
        return r;
      end
      if (i + 1 < POINTS) begin
        x1 = shadow_x[i + 1];
        if (x1 > q) begin
          dx = x1 - x0;
          if (dx == 0) begin
            r.st = ST_BADSEG;
            return r;
          end
          y0  = shadow_y[i];
          y1  = shadow_y[i + 1];
          sum = y0 + ((y1 - y0) * (longint'(q) - x0)) / dx;
          if (sum > 32767) sum = 32767;
          if (sum < -32768) sum = -32768;
          r.y  = sum[DATA_W-1:0];
          r.st = ST_INTERP;
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Drive one transaction, hold it until the core takes it, then update the
  // shadow table or queue the lookup. Idle between bursts of random length.
  task automatic send_item(input func_e f, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] px,
                           input logic signed [DATA_W-1:0] py,
                           input logic signed [DATA_W-1:0] qx,
                           input logic typed, input lookup_t want);
    int gap;
    start         <= 1'b1;
    func_i        <= f;
    point_index_i <= idx;
    point_x_i     <= px;
    point_y_i     <= py;
    query_x_i     <= qx;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (f == FUNC_WRITE) begin
      if (idx < POINTS) begin
        shadow_x[idx] = px;
        shadow_y[idx] = py;
        write_count++;
      end else begin
        ignored_count++;
      end
    end else begin
      pending_lookups.push_back(typed ? want : interpolate_at(qx));
      query_count++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(61, 150);
        1, 2, 3,
        4, 5:    gap = $urandom_range(5, 60);
        default: gap = $urandom_range(1, 4);
      endcase
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Results come as one-cycle strobes; compare each with the oldest lookup owed.
  always @(posedge clk_i) begin
    lookup_t got, want;
    if (rst_ni && done_o === 1'b1) begin
      got.y  = result_y_o;
      got.st = status_e'(status_o);
      if (status_o !== 2'bxx) status_count[status_o]++;
      if (pending_lookups.size() == 0) begin
        note_failure($sformatf("result with nothing owed: y=%0d status=%0d",
                               got.y, status_o));
      end else begin
        want = pending_lookups.pop_front();
        if (result_y_o !== want.y || status_o !== want.st)
          note_failure($sformatf("lookup mismatch: expected y=%0d status=%s, got y=%0d status=%0d",
                                 want.y, want.st.name(), result_y_o, status_o));
      end
    end
  end

  initial begin
    int base, mode, step_max, xv, yv, lo, hi, qv;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_N; r++)
      send_item(directed_rows[r].func, directed_rows[r].idx, directed_rows[r].px,
                directed_rows[r].py, directed_rows[r].qx, directed_rows[r].typed,
                directed_rows[r].want);

    // Random part: mostly sorted tables with random content and queries aimed
    // at them; the rest is stray writes, zero-width openings and wild queries.
    base = write_count + query_count;
    while (write_count + query_count - base < ITEM_TARGET) begin
      mode = $urandom_range(0, 99);
      if (mode < 15) begin
        // reload a whole ascending table; small steps give repeated x
        case ($urandom_range(0, 3))
          0:       step_max = 2;
          1:       step_max = 64;
          2:       step_max = 1024;
          default: step_max = 5900;
        endcase
        xv = -32768 + int'($urandom_range(0, 65535 - 11 * step_max));
        for (int k = 0; k < POINTS; k++) begin
          yv = int'($urandom_range(0, 65535)) - 32768;
          send_item(FUNC_WRITE, IDX_W'(k), xv[DATA_W-1:0], yv[DATA_W-1:0],
                    DATA_W'($urandom), 1'b0, UNTYPED);
          xv += int'($urandom_range(0, step_max));
        end
      end else if (mode < 22) begin
        send_item(FUNC_WRITE, IDX_W'($urandom_range(0, 15)), DATA_W'($urandom),
                  DATA_W'($urandom), DATA_W'($urandom), 1'b0, UNTYPED);
      end else if (mode < 25) begin
        // collapse the first segment to zero width
        send_item(FUNC_WRITE, IDX_W'(1), shadow_x[0], DATA_W'($urandom),
                  DATA_W'($urandom), 1'b0, UNTYPED);
      end else begin
        lo = shadow_x[0];
        hi = shadow_x[POINTS-1];
        if (lo > hi) begin
          qv = lo;
          lo = hi;
          hi = qv;
        end
        mode = $urandom_range(0, 99);
        if (mode < 30)      qv = shadow_x[$urandom_range(0, POINTS-1)];
        else if (mode < 80) qv = lo + int'($urandom_range(0, hi - lo));
        else if (mode < 90) qv = int'($urandom_range(0, 65535)) - 32768;
        else if (mode < 95) qv = $urandom_range(0, 1) ? 32767 : -32768;
        else                qv = hi + int'($urandom_range(1, 300));
        if (qv > 32767) qv = 32767;
        send_item(FUNC_QUERY, IDX_W'($urandom_range(0, 15)), DATA_W'($urandom),
                  DATA_W'($urandom), qv[DATA_W-1:0], 1'b0, UNTYPED);
      end
    end

    // Drain: wait for every owed lookup, then watch for stray strobes.
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d table writes (%0d to slots past the table) and %0d lookups.",
             write_count + ignored_count, ignored_count, query_count);
    $display("Lookups by outcome: exact %0d, interpolated %0d, above table %0d, zero width %0d.",
             status_count[ST_EXACT], status_count[ST_INTERP], status_count[ST_RANGE],
             status_count[ST_BADSEG]);
    if (error_count == 0) begin
      $display("tb_table_linear_interpolator_core: PASS");
    end else begin
      $display("%0d failures in total", error_count);
      $display("tb_table_linear_interpolator_core: FAIL");
    end
    $finish;
  end

endmodule
